// ===== hdl/sha256_pkg.sv =====
// Package with the shared types, constants and the rotate function of the SHA-256 hasher.
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_pos;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUNDS,
        ST_FINAL,
        ST_PAD,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_byte;   // write the input byte into the buffer
        logic       start_pad;   // write 0x80, zeros after it, and the length if it fits
        logic       len_fill;    // write zeros up to byte 56 and the bit count
        logic       init_rounds; // load working variables, clear round counter
        logic       do_round;    // run one round
        logic       add_hash;    // fold working variables into the hash
        logic       rearm;       // restore initial hash and counters
    } dp_cmd_t;

    typedef struct packed {
        logic block_full;  // the byte being loaded fills the block
        logic pad_spills;  // after the pad byte, the length does not fit
        logic round_last;  // the current round is round 63
    } dp_status_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sha256_byte_stream_hasher_top.sv =====
// Top level of the SHA-256 byte stream hasher.
// Each request carries one message byte and/or an end mark. A byte is taken while idle;
// the byte that completes a 64-byte block starts 64 rounds of the single round unit, and
// input stalls while they run. An end mark adds a padding step and one or two
// compressions, then the digest leaves as 8 words (4 when truncate_to_128 is set), one
// per accepted output request, after which the hash re-arms.
`default_nettype none
module sha256_byte_stream_hasher_top
    import sha256_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic       trunc_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic [2:0] out_index;
    logic       out_last;
    logic [31:0] word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trunc_reg <= 1'b0;
        end else if (cfg_we) begin
            trunc_reg <= cfg_wdata;
        end
    end

    sha256_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .in_item         (s_data),
        .truncate_to_128 (trunc_reg),
        .out_ready       (m_ready),
        .out_valid       (m_valid),
        .out_index       (out_index),
        .out_last        (out_last),
        .cmd             (cmd),
        .status          (status)
    );

    sha256_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .data_byte   (s_data.data_byte),
        .cmd         (cmd),
        .status      (status),
        .out_index   (out_index),
        .digest_word (word)
    );

    assign m_data.digest_word = word;
    assign m_data.word_pos    = out_index;
    assign m_data.last_word   = out_last;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while digest is out");
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last_word) |-> (m_data.word_pos == 3'd3
        || m_data.word_pos == 3'd7)) else $error("bad last word index");
    a_idle_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_word) |=> s_ready)
        else $error("no return to idle after digest");

endmodule
`default_nettype wire

// ===== hdl/sha256_ctrl.sv =====
// Controller state machine that sequences byte loading, padding, rounds and digest output.
`default_nettype none
module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_item,
    input  wire logic       truncate_to_128,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [2:0]      out_index,
    output logic            out_last,
    output dp_cmd_t         cmd,
    input  wire dp_status_t status
);

    ctrl_state_t state_reg, state_next;
    logic        final_reg, final_next;  // the block being compressed is the length block
    logic        pend_reg, pend_next;    // an end mark waits for the running block
    logic        spill_reg, spill_next;
    logic [2:0]  idx_reg, idx_next;
    logic        accept;
    logic        last_idx;

    assign accept   = in_valid && in_ready;
    assign last_idx = truncate_to_128 ? (idx_reg == 3'd3) : (idx_reg == 3'd7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        final_next = final_reg;
        pend_next  = pend_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_item.has_byte && status.block_full) begin
                        state_next = ST_ROUNDS;
                        final_next = 1'b0;
                        pend_next  = in_item.is_last;
                    end else if (in_item.is_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUNDS: begin
                if (status.round_last) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (final_reg) begin
                    state_next = ST_EMIT;
                    idx_next   = '0;
                end else if (pend_reg) begin
                    state_next = ST_PAD;
                    pend_next  = 1'b0;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                // The pad byte is written here; a spill needs one extra block.
                state_next = ST_ROUNDS;
                final_next = !status.pad_spills;
                pend_next  = 1'b0;
            end
            ST_EMIT: begin
                if (out_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (last_idx) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // After a spilled pad block, the length block follows directly.
        if (state_reg == ST_FINAL && !final_reg && !pend_reg && spill_reg) begin
            state_next = ST_ROUNDS;
            final_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spill_reg <= 1'b0;
        end else begin
            spill_reg <= spill_next;
        end
    end

    always_comb begin
        spill_next = spill_reg;
        if (state_reg == ST_PAD) begin
            spill_next = status.pad_spills;
        end else if (state_reg == ST_FINAL && spill_reg) begin
            spill_next = 1'b0;
        end
    end

    always_comb begin
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        out_index   = idx_reg;
        out_last    = last_idx;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready      = 1'b1;
                cmd.load_byte = accept && in_item.has_byte;
                cmd.init_rounds = accept && in_item.has_byte && status.block_full;
            end
            ST_ROUNDS: cmd.do_round = 1'b1;
            ST_FINAL: begin
                cmd.add_hash = 1'b1;
                if (!final_reg && !pend_reg && spill_reg) begin
                    cmd.len_fill    = 1'b1;
                    cmd.init_rounds = 1'b1;
                end
            end
            ST_PAD: begin
                cmd.start_pad   = 1'b1;
                cmd.init_rounds = 1'b1;
            end
            ST_EMIT: begin
                out_valid = 1'b1;
                cmd.rearm = out_ready && last_idx;
            end
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/sha256_dp.sv =====
// Datapath with the block buffer, message schedule, round unit and hash registers.
`default_nettype none
module sha256_dp
    import sha256_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  data_byte,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       status,
    input  wire logic [2:0]  out_index,
    output logic [31:0]      digest_word
);

    logic [31:0] blk_reg [16];   // block as big-endian words; doubles as schedule window
    logic [31:0] blk_next [16];
    logic [31:0] hash_reg [8], hash_next [8];
    logic [31:0] v_reg [8], v_next [8];
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] bytes_reg, bytes_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [63:0] bits;
    logic [31:0] w_new, s0, s1, t1, t2;
    logic [5:0]  pad_pos;

    assign bits = {bytes_reg, 3'b000};
    assign status.block_full = (fill_reg == 6'd63);
    assign status.pad_spills = (fill_reg >= LENGTH_POS);
    assign status.round_last = (rnd_reg == 6'd63);
    assign digest_word = hash_reg[out_index];
    assign pad_pos = fill_reg;

    assign s0 = ror32(blk_reg[1], 7) ^ ror32(blk_reg[1], 18) ^ (blk_reg[1] >> 3);
    assign s1 = ror32(blk_reg[14], 17) ^ ror32(blk_reg[14], 19) ^ (blk_reg[14] >> 10);
    assign w_new = s1 + blk_reg[9] + s0 + blk_reg[0];
    assign t1 = v_reg[7] + (ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[rnd_reg] + blk_reg[0];
    assign t2 = (ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb begin
        blk_next   = blk_reg;
        hash_next  = hash_reg;
        v_next     = v_reg;
        fill_next  = fill_reg;
        bytes_next = bytes_reg;
        rnd_next   = rnd_reg;
        if (cmd.load_byte) begin
            blk_next[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] = data_byte;
            fill_next  = fill_reg + 6'd1;
            bytes_next = bytes_reg + 61'd1;
        end
        if (cmd.start_pad) begin
            // Pad byte, zeros after it, and the length if it fits in this block.
            for (int i = 0; i < 64; i++) begin
                if (i == pad_pos) begin
                    blk_next[i/4][8*(3-i%4) +: 8] = PAD_BYTE;
                end else if (i > pad_pos) begin
                    blk_next[i/4][8*(3-i%4) +: 8] = 8'h00;
                end
            end
            if (pad_pos < LENGTH_POS) begin
                blk_next[14] = bits[63:32];
                blk_next[15] = bits[31:0];
            end
        end
        if (cmd.len_fill) begin
            for (int i = 0; i < 14; i++) begin
                blk_next[i] = '0;
            end
            blk_next[14] = bits[63:32];
            blk_next[15] = bits[31:0];
        end
        if (cmd.init_rounds) begin
            v_next   = hash_next;
            rnd_next = '0;
            fill_next = '0;
        end
        if (cmd.do_round) begin
            for (int i = 0; i < 15; i++) begin
                blk_next[i] = blk_reg[i+1];
            end
            blk_next[15] = w_new;
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            rnd_next  = rnd_reg + 6'd1;
        end
        if (cmd.add_hash) begin
            for (int i = 0; i < 8; i++) begin
                hash_next[i] = hash_reg[i] + v_reg[i];
            end
            if (cmd.init_rounds) begin
                v_next = hash_next;
            end
        end
        if (cmd.rearm) begin
            hash_next  = INIT_HASH;
            fill_next  = '0;
            bytes_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        v_reg   <= v_next;
        rnd_reg <= rnd_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= INIT_HASH;
            fill_reg  <= '0;
            bytes_reg <= '0;
        end else begin
            hash_reg  <= hash_next;
            fill_reg  <= fill_next;
            bytes_reg <= bytes_next;
        end
    end

endmodule
`default_nettype wire
